>>> design/ffa_pkg.sv
// Shared types, codes and helpers for the first-fit aligned allocator.
`default_nettype none
package ffa_pkg;

  localparam int HEADER_BYTES_DEF     = 16;
  localparam int MAX_FREE_EXTENTS_DEF = 16;
  localparam int MAX_LIVE_ALLOCS_DEF  = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_HEAP_BASE = 1'b0,
    REG_HEAP_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LSCAN,
    S_ASCAN_A,
    S_ASCAN_B,
    S_SHDN,
    S_SPLIT2,
    S_SHUP,
    S_LFIND,
    S_FPOS,
    S_FCNT,
    S_FMRG,
    S_FLAST,
    S_DONE
  } state_t;

  // Round an alignment down to its highest set bit; zero counts as one.
  function automatic logic [12:0] pow2_floor(input logic [12:0] a);
    logic [12:0] p;
    p = 13'd1;
    for (int i = 0; i < 13; i++) begin
      if (a[i]) p = 13'(1) << i;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

>>> design/ffa_ext_tbl.sv
// Free extent table: base and length per entry, one read and one write port.
`default_nettype none
module ffa_ext_tbl
  import ffa_pkg::*;
#(
  parameter int MAX_FREE_EXTENTS = MAX_FREE_EXTENTS_DEF,
  localparam int EI = $clog2(MAX_FREE_EXTENTS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [EI-1:0] rd_idx,
  output logic      [31:0]   rd_base,
  output logic      [31:0]   rd_len,
  input  wire logic          we,
  input  wire logic [EI-1:0] wr_idx,
  input  wire logic [31:0]   wr_base,
  input  wire logic [31:0]   wr_len
);

  logic [31:0] base_r [MAX_FREE_EXTENTS];
  logic [31:0] len_r  [MAX_FREE_EXTENTS];

  // Write one entry; reset leaves an empty heap at address zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_FREE_EXTENTS; i++) begin
        base_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else if (we) begin
      base_r[wr_idx] <= wr_base;
      len_r[wr_idx]  <= wr_len;
    end
  end

  assign rd_base = base_r[rd_idx];
  assign rd_len  = len_r[rd_idx];

endmodule
`default_nettype wire

>>> design/ffa_live_tbl.sv
// Live allocation table: valid flag, granted address and size per slot.
`default_nettype none
module ffa_live_tbl
  import ffa_pkg::*;
#(
  parameter int MAX_LIVE_ALLOCS = MAX_LIVE_ALLOCS_DEF,
  localparam int LI = (MAX_LIVE_ALLOCS > 1) ? $clog2(MAX_LIVE_ALLOCS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [LI-1:0] rd_idx,
  output logic               rd_valid,
  output logic      [31:0]   rd_addr,
  output logic      [31:0]   rd_len,
  input  wire logic          set,
  input  wire logic          clr,
  input  wire logic          clr_all,
  input  wire logic [LI-1:0] wr_idx,
  input  wire logic [31:0]   wr_addr,
  input  wire logic [31:0]   wr_len
);

  logic        valid_r [MAX_LIVE_ALLOCS];
  logic [31:0] addr_r  [MAX_LIVE_ALLOCS];
  logic [31:0] len_r   [MAX_LIVE_ALLOCS];

  // Track which slots hold a live grant
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      for (int i = 0; i < MAX_LIVE_ALLOCS; i++) valid_r[i] <= 1'b0;
    end else if (set) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (clr) begin
      valid_r[wr_idx] <= 1'b0;
    end
  end

  // Record address and size of a new grant
  always_ff @(posedge clk) begin
    if (set) begin
      addr_r[wr_idx] <= wr_addr;
      len_r[wr_idx]  <= wr_len;
    end
  end

  assign rd_valid = valid_r[rd_idx];
  assign rd_addr  = addr_r[rd_idx];
  assign rd_len   = len_r[rd_idx];

endmodule
`default_nettype wire

>>> design/ffa_ctrl.sv
// Sequencer and shared datapath: scans, shifts and merges the tables.
`default_nettype none
module ffa_ctrl
  import ffa_pkg::*;
#(
  parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
  parameter int MAX_FREE_EXTENTS = MAX_FREE_EXTENTS_DEF,
  parameter int MAX_LIVE_ALLOCS  = MAX_LIVE_ALLOCS_DEF,
  localparam int EI = $clog2(MAX_FREE_EXTENTS),
  localparam int LI = (MAX_LIVE_ALLOCS > 1) ? $clog2(MAX_LIVE_ALLOCS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // request and result handshakes
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          in_op,
  input  wire logic [31:0]   in_req,
  input  wire logic [12:0]   in_align,
  input  wire logic [31:0]   in_rel,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic      [31:0]   out_addr,
  output logic      [1:0]    out_status,
  // configuration
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_data,
  // extent table
  output logic      [EI-1:0] e_rd_idx,
  input  wire logic [31:0]   e_base,
  input  wire logic [31:0]   e_len,
  output logic               e_we,
  output logic      [EI-1:0] e_wr_idx,
  output logic      [31:0]   e_wr_base,
  output logic      [31:0]   e_wr_len,
  // live table
  output logic      [LI-1:0] l_rd_idx,
  input  wire logic          l_valid,
  input  wire logic [31:0]   l_addr,
  input  wire logic [31:0]   l_len,
  output logic               l_set,
  output logic               l_clr,
  output logic               l_clr_all,
  output logic      [LI-1:0] l_wr_idx,
  output logic      [31:0]   l_wr_addr,
  output logic      [31:0]   l_wr_len
);

  localparam int CW = $clog2(MAX_FREE_EXTENTS + 1);
  localparam int SW = $clog2(MAX_FREE_EXTENTS + 2);

  state_t        state_r, state_nxt;
  logic          op_r, op_nxt;
  logic [31:0]   req_r, req_nxt;
  logic [12:0]   alp_r, alp_nxt;
  logic [31:0]   rel_r, rel_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [LI-1:0] lidx_r, lidx_nxt;
  logic [LI-1:0] slot_r, slot_nxt;
  logic          slot_ok_r, slot_ok_nxt;
  logic [EI-1:0] hit_r, hit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] m_r, m_nxt;
  logic [SW-1:0] pos_r, pos_nxt;
  logic [33:0]   al_r, al_nxt;
  logic [32:0]   end_r, end_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [31:0]   top_r, top_nxt;
  logic [31:0]   tl_r, tl_nxt;
  logic [31:0]   gl_r, gl_nxt;
  logic [31:0]   rb_r, rb_nxt;
  logic [32:0]   rl_r, rl_nxt;
  logic [31:0]   accb_r, accb_nxt;
  logic [41:0]   accl_r, accl_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [31:0]   oaddr_r, oaddr_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic [31:0]   heap_base_r, heap_base_nxt;
  logic [31:0]   heap_size_r, heap_size_nxt;

  // Shared datapath terms
  logic [SW-1:0] cnt_s;
  logic [12:0]   alm1;
  logic [33:0]   al_c;
  logic [32:0]   end_c;
  logic [34:0]   top_c;
  logic [33:0]   hdr_c;
  logic [34:0]   tail_c;
  logic [33:0]   gap_c;
  logic          fit, has_tail, has_gap;
  logic [31:0]   mb;
  logic [32:0]   ml;
  logic [41:0]   msum;
  logic          touch, last;
  logic [SW-1:0] mnx;

  assign cnt_s    = SW'(cnt_r);
  assign alm1     = alp_r - 13'd1;
  assign al_c     = ({2'b0, e_base} + 34'(HEADER_BYTES) + {21'b0, alm1}) & ~{21'b0, alm1};
  assign end_c    = {1'b0, e_base} + {1'b0, e_len};
  assign top_c    = {1'b0, al_r} + {3'b0, req_r};
  assign hdr_c    = al_r - 34'(HEADER_BYTES);
  assign tail_c   = {2'b0, end_r} - top_c;
  assign gap_c    = hdr_c - {2'b0, base_r};
  assign fit      = (top_c <= 35'h0_FFFF_FFFF) && (top_c <= {2'b0, end_r});
  assign has_tail = top_c < {2'b0, end_r};
  assign has_gap  = hdr_c > {2'b0, base_r};

  // Pick the merge element: the freed region at its slot, table entries around it
  always_comb begin
    if (idx_r == pos_r) begin
      mb = rb_r;
      ml = rl_r;
    end else begin
      mb = e_base;
      ml = {1'b0, e_len};
    end
  end

  assign msum  = {10'b0, accb_r} + accl_r;
  assign touch = msum == {10'b0, mb};
  assign last  = idx_r == cnt_s;
  // Group count including the current element; the first element opens group one
  assign mnx   = (idx_r == '0) ? SW'(1) : (!touch ? SW'(m_r + SW'(1)) : m_r);

  // Hold all state; clear control on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CW'(1);
      ovalid_r    <= 1'b0;
      heap_base_r <= '0;
      heap_size_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovalid_r    <= ovalid_nxt;
      heap_base_r <= heap_base_nxt;
      heap_size_r <= heap_size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    req_r      <= req_nxt;
    alp_r      <= alp_nxt;
    rel_r      <= rel_nxt;
    idx_r      <= idx_nxt;
    lidx_r     <= lidx_nxt;
    slot_r     <= slot_nxt;
    slot_ok_r  <= slot_ok_nxt;
    hit_r      <= hit_nxt;
    m_r        <= m_nxt;
    pos_r      <= pos_nxt;
    al_r       <= al_nxt;
    end_r      <= end_nxt;
    base_r     <= base_nxt;
    top_r      <= top_nxt;
    tl_r       <= tl_nxt;
    gl_r       <= gl_nxt;
    rb_r       <= rb_nxt;
    rl_r       <= rl_nxt;
    accb_r     <= accb_nxt;
    accl_r     <= accl_nxt;
    oaddr_r    <= oaddr_nxt;
    ost_r      <= ost_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
  end

  // Sequencer: next state, table ports and result
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    alp_nxt       = alp_r;
    rel_nxt       = rel_r;
    idx_nxt       = idx_r;
    lidx_nxt      = lidx_r;
    slot_nxt      = slot_r;
    slot_ok_nxt   = slot_ok_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    pos_nxt       = pos_r;
    al_nxt        = al_r;
    end_nxt       = end_r;
    base_nxt      = base_r;
    top_nxt       = top_r;
    tl_nxt        = tl_r;
    gl_nxt        = gl_r;
    rb_nxt        = rb_r;
    rl_nxt        = rl_r;
    accb_nxt      = accb_r;
    accl_nxt      = accl_r;
    ovalid_nxt    = ovalid_r;
    oaddr_nxt     = oaddr_r;
    ost_nxt       = ost_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    heap_base_nxt = heap_base_r;
    heap_size_nxt = heap_size_r;

    in_tready = 1'b0;
    cfg_ready = 1'b0;
    e_rd_idx  = idx_r[EI-1:0];
    e_we      = 1'b0;
    e_wr_idx  = idx_r[EI-1:0];
    e_wr_base = e_base;
    e_wr_len  = e_len;
    l_rd_idx  = lidx_r;
    l_set     = 1'b0;
    l_clr     = 1'b0;
    l_clr_all = 1'b0;
    l_wr_idx  = slot_r;
    l_wr_addr = al_r[31:0];
    l_wr_len  = req_r;

    // Drain the output register
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // A register write takes the cycle; hold off requests meanwhile
        in_tready = !cfg_valid;
        cfg_ready = 1'b1;
        if (cfg_valid) begin
          // Restart the heap as one extent
          unique case (cfg_reg_t'(cfg_index))
            REG_HEAP_BASE: heap_base_nxt = cfg_data;
            REG_HEAP_SIZE: heap_size_nxt = cfg_data;
            default: ;
          endcase
          e_we      = 1'b1;
          e_wr_idx  = '0;
          e_wr_base = (cfg_reg_t'(cfg_index) == REG_HEAP_BASE) ? cfg_data : heap_base_r;
          e_wr_len  = (cfg_reg_t'(cfg_index) == REG_HEAP_SIZE) ? cfg_data : heap_size_r;
          cnt_nxt   = CW'(1);
          l_clr_all = 1'b1;
        end else if (in_tvalid) begin
          op_nxt   = in_op;
          req_nxt  = in_req;
          alp_nxt  = pow2_floor(in_align);
          rel_nxt  = in_rel;
          lidx_nxt = '0;
          idx_nxt  = '0;
          state_nxt = (opcode_t'(in_op) == OP_ALLOC) ? S_LSCAN : S_LFIND;
        end
      end

      // Find the first free live slot
      S_LSCAN: begin
        if (!l_valid) begin
          slot_nxt    = lidx_r;
          slot_ok_nxt = 1'b1;
          state_nxt   = S_ASCAN_A;
        end else if (lidx_r == LI'(MAX_LIVE_ALLOCS - 1)) begin
          slot_ok_nxt = 1'b0;
          state_nxt   = S_ASCAN_A;
        end else begin
          lidx_nxt = lidx_r + LI'(1);
        end
      end

      // Align the address past the header of one extent; report no fit once every extent is tried
      S_ASCAN_A: begin
        if (idx_r >= cnt_s) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_NOFIT;
          state_nxt    = S_DONE;
        end else begin
          al_nxt    = al_c;
          end_nxt   = end_c;
          base_nxt  = e_base;
          state_nxt = S_ASCAN_B;
        end
      end

      // Check the fit and pick the table update
      S_ASCAN_B: begin
        top_nxt = top_c[31:0];
        tl_nxt  = tail_c[31:0];
        gl_nxt  = gap_c[31:0];
        hit_nxt = idx_r[EI-1:0];
        if (!fit) begin
          idx_nxt   = idx_r + SW'(1);
          state_nxt = S_ASCAN_A;
        end else if (!slot_ok_r) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_FULL;
          state_nxt    = S_DONE;
        end else if (has_tail && has_gap) begin
          if (cnt_r >= CW'(MAX_FREE_EXTENTS)) begin
            res_addr_nxt = '0;
            res_st_nxt   = ST_FULL;
            state_nxt    = S_DONE;
          end else begin
            idx_nxt   = cnt_s;
            state_nxt = S_SHDN;
          end
        end else if (has_tail) begin
          e_we      = 1'b1;
          e_wr_base = top_c[31:0];
          e_wr_len  = tail_c[31:0];
          l_set        = 1'b1;
          res_addr_nxt = al_r[31:0];
          res_st_nxt   = ST_OK;
          state_nxt    = S_DONE;
        end else if (has_gap) begin
          e_we      = 1'b1;
          e_wr_base = base_r;
          e_wr_len  = gap_c[31:0];
          l_set        = 1'b1;
          res_addr_nxt = al_r[31:0];
          res_st_nxt   = ST_OK;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_SHUP;
        end
      end

      // Open a slot after the split extent, one entry a cycle
      S_SHDN: begin
        e_we = 1'b1;
        if (idx_r == SW'({1'b0, hit_r}) + SW'(1)) begin
          e_wr_base = top_r;
          e_wr_len  = tl_r;
          state_nxt = S_SPLIT2;
        end else begin
          e_rd_idx = EI'(idx_r - SW'(1));
          idx_nxt  = idx_r - SW'(1);
        end
      end

      S_SPLIT2: begin
        e_we         = 1'b1;
        e_wr_idx     = hit_r;
        e_wr_base    = base_r;
        e_wr_len     = gl_r;
        cnt_nxt      = cnt_r + CW'(1);
        l_set        = 1'b1;
        res_addr_nxt = al_r[31:0];
        res_st_nxt   = ST_OK;
        state_nxt    = S_DONE;
      end

      // Close the gap left by a used-up extent
      S_SHUP: begin
        if (idx_r + SW'(1) < cnt_s) begin
          e_rd_idx = EI'(idx_r + SW'(1));
          e_we     = 1'b1;
          idx_nxt  = idx_r + SW'(1);
        end else begin
          cnt_nxt      = cnt_r - CW'(1);
          l_set        = 1'b1;
          res_addr_nxt = al_r[31:0];
          res_st_nxt   = ST_OK;
          state_nxt    = S_DONE;
        end
      end

      // Look up the live grant being freed
      S_LFIND: begin
        if (l_valid && l_addr == rel_r) begin
          slot_nxt  = lidx_r;
          rb_nxt    = rel_r - 32'(HEADER_BYTES);
          rl_nxt    = {1'b0, l_len} + 33'(HEADER_BYTES);
          idx_nxt   = '0;
          state_nxt = S_FPOS;
        end else if (lidx_r == LI'(MAX_LIVE_ALLOCS - 1)) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_UNKNOWN;
          state_nxt    = S_DONE;
        end else begin
          lidx_nxt = lidx_r + LI'(1);
        end
      end

      // Find the insert position in address order
      S_FPOS: begin
        if (idx_r >= cnt_s) begin
          pos_nxt   = cnt_s;
          idx_nxt   = '0;
          state_nxt = S_FCNT;
        end else if (e_base > rb_r) begin
          pos_nxt   = idx_r;
          idx_nxt   = '0;
          state_nxt = S_FCNT;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end

      // Count extents after merging, no writes
      S_FCNT: begin
        if (idx_r > pos_r) e_rd_idx = EI'(idx_r - SW'(1));
        m_nxt = (idx_r == '0) ? SW'(1) : mnx;
        if (idx_r == '0 || !touch) begin
          accb_nxt = mb;
          accl_nxt = {9'b0, ml};
        end else begin
          accl_nxt = accl_r + {9'b0, ml};
        end
        if (last) begin
          if (mnx > SW'(MAX_FREE_EXTENTS)) begin
            res_addr_nxt = '0;
            res_st_nxt   = ST_FULL;
            state_nxt    = S_DONE;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_FMRG;
          end
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end

      // Merge pass: write each closed group in place
      S_FMRG: begin
        if (idx_r > pos_r) e_rd_idx = EI'(idx_r - SW'(1));
        m_nxt = (idx_r == '0) ? SW'(1) : mnx;
        if (idx_r == '0 || !touch) begin
          accb_nxt = mb;
          accl_nxt = {9'b0, ml};
        end else begin
          accl_nxt = accl_r + {9'b0, ml};
        end
        if (idx_r != '0 && !touch) begin
          e_we      = 1'b1;
          e_wr_idx  = EI'(m_r - SW'(1));
          e_wr_base = accb_r;
          e_wr_len  = accl_r[31:0];
        end
        if (last) state_nxt = S_FLAST;
        else idx_nxt = idx_r + SW'(1);
      end

      S_FLAST: begin
        e_we         = 1'b1;
        e_wr_idx     = EI'(m_r - SW'(1));
        e_wr_base    = accb_r;
        e_wr_len     = accl_r[31:0];
        cnt_nxt      = CW'(m_r);
        l_clr        = 1'b1;
        res_addr_nxt = '0;
        res_st_nxt   = ST_OK;
        state_nxt    = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oaddr_nxt  = res_addr_r;
          ost_nxt    = res_st_r;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_addr   = oaddr_r;
  assign out_status = ost_r;

endmodule
`default_nettype wire

>>> design/first_fit_aligned_allocator.sv
// Top level of the first-fit aligned heap allocator.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tuser: opcode; tdata: request, align, release
//   out_     out  out_tvalid/out_tready  tdata: granted address, status
//   cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request at a time through one shared sequencer and datapath.
// Allocate: a scan of the live table for a free slot, a fit check per extent
// tried, then a shift of the extent table where needed. Free: a lookup of the
// grant in the live table, a search for the insert position, then a counting
// pass and a writing pass to merge touching extents. A register write holds
// off requests while it is presented.
// Reset is synchronous: an empty heap at address zero, no live grants.
// A finished result waits in the output register; the next request may be
// accepted while it is held.
`default_nettype none
module first_fit_aligned_allocator
  import ffa_pkg::*;
#(
  parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
  parameter int MAX_FREE_EXTENTS = MAX_FREE_EXTENTS_DEF,
  parameter int MAX_LIVE_ALLOCS  = MAX_LIVE_ALLOCS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // request_bytes[31:0], align_bytes[44:32],
                                       // release_address[76:45], zero pad
  input  wire logic        in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // granted_address[31:0], status[33:32], zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int EI = $clog2(MAX_FREE_EXTENTS);
  localparam int LI = (MAX_LIVE_ALLOCS > 1) ? $clog2(MAX_LIVE_ALLOCS) : 1;

  logic [EI-1:0] e_rd_idx, e_wr_idx;
  logic [31:0]   e_base, e_len, e_wr_base, e_wr_len;
  logic          e_we;
  logic [LI-1:0] l_rd_idx, l_wr_idx;
  logic          l_valid, l_set, l_clr, l_clr_all;
  logic [31:0]   l_addr, l_len, l_wr_addr, l_wr_len;
  logic [31:0]   out_addr;
  logic [1:0]    out_status;

  ffa_ctrl #(
    .HEADER_BYTES     (HEADER_BYTES),
    .MAX_FREE_EXTENTS (MAX_FREE_EXTENTS),
    .MAX_LIVE_ALLOCS  (MAX_LIVE_ALLOCS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_req     (in_tdata[31:0]),
    .in_align   (in_tdata[44:32]),
    .in_rel     (in_tdata[76:45]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_addr   (out_addr),
    .out_status (out_status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .e_rd_idx   (e_rd_idx),
    .e_base     (e_base),
    .e_len      (e_len),
    .e_we       (e_we),
    .e_wr_idx   (e_wr_idx),
    .e_wr_base  (e_wr_base),
    .e_wr_len   (e_wr_len),
    .l_rd_idx   (l_rd_idx),
    .l_valid    (l_valid),
    .l_addr     (l_addr),
    .l_len      (l_len),
    .l_set      (l_set),
    .l_clr      (l_clr),
    .l_clr_all  (l_clr_all),
    .l_wr_idx   (l_wr_idx),
    .l_wr_addr  (l_wr_addr),
    .l_wr_len   (l_wr_len)
  );

  ffa_ext_tbl #(
    .MAX_FREE_EXTENTS (MAX_FREE_EXTENTS)
  ) u_ext (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (e_rd_idx),
    .rd_base (e_base),
    .rd_len  (e_len),
    .we      (e_we),
    .wr_idx  (e_wr_idx),
    .wr_base (e_wr_base),
    .wr_len  (e_wr_len)
  );

  ffa_live_tbl #(
    .MAX_LIVE_ALLOCS (MAX_LIVE_ALLOCS)
  ) u_live (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (l_rd_idx),
    .rd_valid (l_valid),
    .rd_addr  (l_addr),
    .rd_len   (l_len),
    .set      (l_set),
    .clr      (l_clr),
    .clr_all  (l_clr_all),
    .wr_idx   (l_wr_idx),
    .wr_addr  (l_wr_addr),
    .wr_len   (l_wr_len)
  );

  // Pack the result beat
  assign out_tdata = {6'b0, out_status, out_addr};

endmodule
`default_nettype wire

>>> tb/ffa_checker.sv
// Allocator scoreboard: watches all channels, predicts each result and compares.
`timescale 1ns / 100ps
module ffa_checker
  import ffa_pkg::*;
#(
  parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
  parameter int MAX_FREE_EXTENTS = MAX_FREE_EXTENTS_DEF,
  parameter int MAX_LIVE_ALLOCS  = MAX_LIVE_ALLOCS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam longint unsigned MASK32 = 64'hFFFF_FFFF;

  typedef struct {
    logic [31:0] grant;
    status_t     st;
  } heap_result_t;

  heap_result_t result_q[$];

  logic [31:0]     heap_base_q, heap_size_q;
  longint unsigned ext_base [MAX_FREE_EXTENTS];
  longint unsigned ext_len  [MAX_FREE_EXTENTS];
  int              ext_cnt;
  longint unsigned live_addr [MAX_LIVE_ALLOCS];
  longint unsigned live_len  [MAX_LIVE_ALLOCS];
  bit              live_ok   [MAX_LIVE_ALLOCS];

  // Collapse the heap to one extent and drop every grant.
  function automatic void restart_heap();
    for (int i = 0; i < MAX_FREE_EXTENTS; i++) begin
      ext_base[i] = 0;
      ext_len[i]  = 0;
    end
    for (int i = 0; i < MAX_LIVE_ALLOCS; i++) live_ok[i] = 1'b0;
    ext_base[0] = heap_base_q;
    ext_len[0]  = heap_size_q;
    ext_cnt     = 1;
  endfunction

  function automatic longint unsigned align_floor(logic [12:0] a);
    longint unsigned p;
    p = 1;
    while (a != 0 && (p << 1) <= a) p = p << 1;
    return p;
  endfunction

  function automatic heap_result_t predict_alloc(longint unsigned bytes, logic [12:0] align);
    heap_result_t    r;
    longint unsigned p, b, e, al, top, hdr;
    int              slot;
    p = align_floor(align);
    r.grant = '0;
    r.st    = ST_NOFIT;
    for (int i = 0; i < ext_cnt && i < MAX_FREE_EXTENTS; i++) begin
      b   = ext_base[i];
      e   = b + ext_len[i];
      al  = (b + HEADER_BYTES + p - 1) & ~(p - 1);
      top = al + bytes;
      hdr = al - HEADER_BYTES;
      if (top > MASK32 || top > e || hdr < b) continue;
      slot = -1;
      for (int s = MAX_LIVE_ALLOCS - 1; s >= 0; s--) if (!live_ok[s]) slot = s;
      if (slot < 0) begin
        r.st = ST_FULL;
        return r;
      end
      if (top < e) begin
        if (hdr > b) begin
          if (ext_cnt >= MAX_FREE_EXTENTS) begin
            r.st = ST_FULL;
            return r;
          end
          for (int j = ext_cnt; j > i + 1; j--) begin
            ext_base[j] = ext_base[j-1];
            ext_len[j]  = ext_len[j-1];
          end
          ext_len[i]    = (hdr - b) & MASK32;
          ext_base[i+1] = top & MASK32;
          ext_len[i+1]  = (e - top) & MASK32;
          ext_cnt++;
        end else begin
          ext_base[i] = top & MASK32;
          ext_len[i]  = (e - top) & MASK32;
        end
      end else if (hdr > b) begin
        ext_len[i] = (hdr - b) & MASK32;
      end else begin
        for (int j = i; j + 1 < ext_cnt; j++) begin
          ext_base[j] = ext_base[j+1];
          ext_len[j]  = ext_len[j+1];
        end
        ext_cnt--;
      end
      live_ok[slot]   = 1'b1;
      live_addr[slot] = al & MASK32;
      live_len[slot]  = bytes;
      r.grant = al[31:0];
      r.st    = ST_OK;
      return r;
    end
    return r;
  endfunction

  function automatic status_t predict_free(longint unsigned addr);
    longint unsigned tb_base [MAX_FREE_EXTENTS+1];
    longint unsigned tb_len  [MAX_FREE_EXTENTS+1];
    longint unsigned rb, rl;
    int              k, n, pos, m;
    k = -1;
    for (int i = MAX_LIVE_ALLOCS - 1; i >= 0; i--)
      if (live_ok[i] && live_addr[i] == addr) k = i;
    if (k < 0) return ST_UNKNOWN;
    rb  = (addr - HEADER_BYTES) & MASK32;
    rl  = live_len[k] + HEADER_BYTES;
    pos = ext_cnt;
    for (int i = ext_cnt - 1; i >= 0; i--) if (ext_base[i] > rb) pos = i;
    // Insert the returned region in address order.
    n = 0;
    for (int i = 0; i <= ext_cnt; i++) begin
      if (i == pos) begin
        tb_base[n] = rb;
        tb_len[n]  = rl;
        n++;
      end
      if (i < ext_cnt) begin
        tb_base[n] = ext_base[i];
        tb_len[n]  = ext_len[i];
        n++;
      end
    end
    // Merge touching neighbors.
    m = 1;
    for (int i = 1; i < n; i++) begin
      if (tb_base[m-1] + tb_len[m-1] == tb_base[i]) begin
        tb_len[m-1] += tb_len[i];
      end else begin
        tb_base[m] = tb_base[i];
        tb_len[m]  = tb_len[i];
        m++;
      end
    end
    if (m > MAX_FREE_EXTENTS) return ST_FULL;
    for (int i = 0; i < m; i++) begin
      ext_base[i] = tb_base[i] & MASK32;
      ext_len[i]  = tb_len[i] & MASK32;
    end
    ext_cnt    = m;
    live_ok[k] = 1'b0;
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    heap_result_t exp_r, got;
    if (!rst_n) begin
      heap_base_q = '0;
      heap_size_q = '0;
      restart_heap();
      result_q.delete();
      fail_count <= 0;
    end else begin
      // Register write resets the heap.
      if (cfg_valid && cfg_ready) begin
        if (cfg_reg_t'(cfg_index) == REG_HEAP_BASE) heap_base_q = cfg_data;
        else heap_size_q = cfg_data;
        restart_heap();
      end
      // Predict the result of each accepted request.
      if (in_tvalid && in_tready) begin
        exp_r.grant = '0;
        if (opcode_t'(in_tuser) == OP_ALLOC) begin
          exp_r = predict_alloc(in_tdata[31:0], in_tdata[44:32]);
        end else begin
          exp_r.st = predict_free(in_tdata[76:45]);
        end
        result_q.push_back(exp_r);
      end
      // Compare each result beat with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got.grant = out_tdata[31:0];
        got.st    = status_t'(out_tdata[33:32]);
        if (result_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result grant=%h status=%0d", $realtime, got.grant, got.st);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (got.grant !== exp_r.grant || got.st !== exp_r.st) begin
            if (fail_count < 10)
              $display("%0t: expected grant=%h status=%0d, got grant=%h status=%0d",
                       $realtime, exp_r.grant, exp_r.st, got.grant, got.st);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= result_q.size();
  end

endmodule

>>> tb/tb.sv
// Allocator testbench top: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  import ffa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [79:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [39:0] out_tdata;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending, idle_cycles;

  opcode_t     sent_ops[$];
  logic [31:0] granted_q[$];
  logic [31:0] last_freed;
  bit          send_burst, recv_burst;

  first_fit_aligned_allocator i_dut (.*);

  ffa_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort when no beat moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 3000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stall per beat, record successful grants.
  initial begin
    opcode_t op;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!recv_burst) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      op = sent_ops.pop_front();
      if (op == OP_ALLOC && status_t'(out_tdata[33:32]) == ST_OK)
        granted_q.push_back(out_tdata[31:0]);
      if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
    end
  end

  task automatic send_req(opcode_t op, logic [31:0] bytes, logic [12:0] align,
                          logic [31:0] addr);
    if (!send_burst) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {3'b000, addr, align, bytes};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_ops.push_back(op);
    @(negedge clk);
  endtask

  // Hold until every result is back, then let the block go quiet.
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending != 0 || sent_ops.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic new_heap(logic [31:0] base, logic [31:0] size);
    settle();
    write_reg(REG_HEAP_BASE, base);
    write_reg(REG_HEAP_SIZE, size);
    granted_q.delete();
  endtask

  task automatic free_oldest();
    logic [31:0] a;
    settle();
    a = granted_q.size() ? granted_q.pop_front() : 32'h1234;
    send_req(OP_FREE, $urandom, 13'($urandom_range(0, 8191)), a);
    last_freed = a;
  endtask

  task automatic random_req();
    logic [31:0] bytes, addr;
    logic [12:0] align;
    int          pick, k;
    pick  = $urandom_range(0, 9);
    bytes = pick < 8 ? $urandom_range(0, 256) : pick == 8 ? $urandom_range(0, 8192) : $urandom;
    align = $urandom_range(0, 9) < 7 ? 13'd1 << $urandom_range(0, 12)
                                     : 13'($urandom_range(0, 8191));
    if ($urandom_range(0, 99) < 55) begin
      send_req(OP_ALLOC, bytes, align, $urandom);
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 15 && granted_q.size() != 0) begin
        k    = $urandom_range(0, granted_q.size() - 1);
        addr = granted_q[k];
        granted_q.delete(k);
      end else if (pick < 17) begin
        addr = last_freed;
      end else begin
        addr = $urandom;
      end
      last_freed = addr;
      send_req(OP_FREE, bytes, align, addr);
    end
  endtask

  initial begin
    logic [31:0] bases[5] = '{32'h0000_1000, 32'h0000_0000, 32'hFFFF_F000,
                              32'h7FFF_0000, 32'hFFFF_FFFF};
    logic [31:0] sizes[5] = '{32'h0000_2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'h0000_0600, 32'h0000_0000};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = 1'b0;
    cfg_data   = '0;
    last_freed = '0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty heap after reset: nothing fits.
    send_req(OP_ALLOC, 32'd0, 13'd1, 32'd0);
    new_heap(32'h0000_1000, 32'h0000_2000);
    // Zero, odd and widest alignments, zero and huge requests.
    send_req(OP_ALLOC, 32'd0, 13'd0, 32'hFFFF_FFFF);
    send_req(OP_ALLOC, 32'd100, 13'd3, 32'd0);
    send_req(OP_ALLOC, 32'd32, 13'd4096, 32'd0);
    send_req(OP_ALLOC, 32'hFFFF_FFFF, 13'h1FFF, 32'd0);
    send_req(OP_FREE, 32'd0, 13'd1, 32'h0000_1234);
    // Free a grant, then free it again.
    free_oldest();
    send_req(OP_FREE, 32'd0, 13'd1, last_freed);
    // Fill the grant table until it overflows.
    repeat (17) send_req(OP_ALLOC, 32'd16, 13'd16, 32'd0);

    // Random phases, one heap shape per phase.
    for (int ph = 0; ph < 5; ph++) begin
      new_heap(bases[ph], sizes[ph]);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
        random_req();
      end
    end

    settle();
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
design/ffa_pkg.sv
design/ffa_ext_tbl.sv
design/ffa_live_tbl.sv
design/ffa_ctrl.sv
design/first_fit_aligned_allocator.sv
tb/ffa_checker.sv
tb/tb.sv
